// File: hdl/sva_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the synth voice core: field widths, register indexes,
// envelope stage and waveform codes, sine polynomial coefficients, and the
// widths of the serial multiplier and divider. Depends on nothing.
package sva_pkg;

	// Field and register widths.
	localparam int PHASE_W    = 32;
	localparam int Q15_W      = 16;
	localparam int LEN_W      = 24;
	localparam int ELAPSED_W  = 27;
	localparam int STAGE_W    = 3;
	localparam int WAVE_SEL_W = 2;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [Q15_W-1:0]     Q15_ONE     = 16'd32768;
	localparam logic [Q15_W-1:0]     Q15_MAX_POS = 16'd32767;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEN    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_LEN     = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_LEN      = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEN   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_WAVE_SELECT   = 4'd7;

	// Register reset values.
	localparam logic [PHASE_W-1:0]    RST_PHASE_STEP    = 32'd42852281;
	localparam logic [Q15_W-1:0]      RST_AMPLITUDE     = 16'd16384;
	localparam logic [LEN_W-1:0]      RST_ATTACK_LEN    = 24'd4410;
	localparam logic [LEN_W-1:0]      RST_DECAY_LEN     = 24'd4410;
	localparam logic [Q15_W-1:0]      RST_SUSTAIN_LEVEL = 16'd22938;
	localparam logic [LEN_W-1:0]      RST_HOLD_LEN      = 24'd22050;
	localparam logic [LEN_W-1:0]      RST_RELEASE_LEN   = 24'd4410;

	// Envelope stage codes as they appear on env_stage.
	localparam logic [STAGE_W-1:0] STAGE_SILENT  = 3'd0;
	localparam logic [STAGE_W-1:0] STAGE_ATTACK  = 3'd1;
	localparam logic [STAGE_W-1:0] STAGE_DECAY   = 3'd2;
	localparam logic [STAGE_W-1:0] STAGE_HOLD    = 3'd3;
	localparam logic [STAGE_W-1:0] STAGE_RELEASE = 3'd4;

	// Waveform codes.
	localparam logic [WAVE_SEL_W-1:0] WAVE_SINE     = 2'd0;
	localparam logic [WAVE_SEL_W-1:0] WAVE_SQUARE   = 2'd1;
	localparam logic [WAVE_SEL_W-1:0] WAVE_TRIANGLE = 2'd2;
	localparam logic [WAVE_SEL_W-1:0] WAVE_SAWTOOTH = 2'd3;

	// Quarter-wave sine: index bits and polynomial coefficients in Q16.
	localparam int SINE_TABLE_BITS = 10;
	localparam int SIN_X_W         = 17;
	localparam logic [SINE_TABLE_BITS:0] SIN_Q = {1'b1, {SINE_TABLE_BITS{1'b0}}};
	localparam logic [SIN_X_W-1:0] SIN_C1 = 17'd102944;
	localparam logic [SIN_X_W-1:0] SIN_C3 = 17'd42334;
	localparam logic [SIN_X_W-1:0] SIN_C5 = 17'd5223;

	// Digit-serial multiplier.
	localparam int MUL_A_W     = 25;
	localparam int MUL_DIGIT_W = 4;
	localparam int MUL_DIGITS  = 5;
	localparam int MUL_B_W     = MUL_DIGIT_W * MUL_DIGITS;
	localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
	localparam int MUL_CNT_W   = $clog2(MUL_DIGITS);

	// Bit-serial restoring divider.
	localparam int DIV_DEN_W = LEN_W;
	localparam int DIV_Q_W   = 16;
	localparam int DIV_NUM_W = DIV_DEN_W + DIV_Q_W;
	localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

endpackage

// File: hdl/sva_mul.sv
`timescale 1ns / 1ps
// Digit-serial unsigned multiplier: one digit of the second operand per cycle,
// most significant digit first. Depends on sva_pkg.
module sva_mul import sva_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic               done,
	output logic [MUL_P_W-1:0] p
);

	localparam int PP_W = MUL_A_W + MUL_DIGIT_W;

	logic [MUL_A_W-1:0]   a_q;
	logic [MUL_B_W-1:0]   b_q;
	logic [MUL_P_W-1:0]   acc_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [PP_W-1:0]      pp_first;
	logic [PP_W-1:0]      pp_next;

	assign pp_first = a * b[MUL_B_W-1 -: MUL_DIGIT_W];
	assign pp_next  = a_q * b_q[MUL_B_W-1 -: MUL_DIGIT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			b_q    <= '0;
			acc_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				a_q    <= a;
				b_q    <= b << MUL_DIGIT_W;
				acc_q  <= MUL_P_W'(pp_first);
				cnt_q  <= MUL_CNT_W'(MUL_DIGITS - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				acc_q <= (acc_q << MUL_DIGIT_W) + MUL_P_W'(pp_next);
				b_q   <= b_q << MUL_DIGIT_W;
				cnt_q <= cnt_q - MUL_CNT_W'(1);
				if (cnt_q == MUL_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

// File: hdl/sva_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle. The caller
// guarantees that the quotient fits in DIV_Q_W bits. Depends on sva_pkg.
module sva_div import sva_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic                 done,
	output logic [DIV_Q_W-1:0]   quot
);

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_Q_W-1:0]   low_q;
	logic [DIV_Q_W-1:0]   quot_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 fits;

	// Shift the next numerator bit into the partial remainder and try a subtract.
	assign trial = {rem_q, low_q[DIV_Q_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			den_q  <= '0;
			low_q  <= '0;
			quot_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				rem_q  <= num[DIV_NUM_W-1 -: DIV_DEN_W];
				low_q  <= num[DIV_Q_W-1:0];
				den_q  <= den;
				cnt_q  <= DIV_CNT_W'(DIV_Q_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q  <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
				low_q  <= low_q << 1;
				quot_q <= {quot_q[DIV_Q_W-2:0], fits};
				cnt_q  <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// File: hdl/synth_voice_adsr_oscillator_core.sv
`timescale 1ns / 1ps
// Synth voice core: phase-accumulator oscillator shaped by a timed envelope.
// Depends on sva_pkg, sva_mul and sva_div.
//
// Usage. Each input beat (in_valid, in_stall, note_on) is one audio sample
// tick and yields exactly one output beat (sample_out, gain_level, env_stage)
// on the out_valid / out_stall channel. A beat with note_on set restarts the
// envelope timer and enables sound; it never resets the oscillator phase.
// Configuration goes through cfg_valid / cfg_ready with a register index and
// data; cfg_ready is high whenever no sample is being worked on, and writes
// to indexes beyond the register list are dropped.
//
// Sequencing. One sample is worked on at a time. Every product is formed on
// a digit-serial multiplier and every envelope ramp needs a bit-serial
// divide; the sine wave takes four extra products for its quarter-wave
// polynomial. The next input beat can be taken in the cycle after a result
// is handed to the output register.
//
// Reset clears the phase, the timer and the playing flag and loads the
// register defaults; output is silent until the first note_on. If the
// receiver stalls, the finished beat waits in the output register; a second
// finished beat waits in the final state until the register frees up.
module synth_voice_adsr_oscillator_core import sva_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// Input channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     note_on,
	// Output channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [Q15_W-1:0]  sample_out,
	output logic [Q15_W-1:0]         gain_level,
	output logic [STAGE_W-1:0]       env_stage,
	// Configuration write channel
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data
);

	// One-hot sequencer. Each arithmetic state launches one serial operation
	// and waits for its done pulse.
	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_END3    = 13'b0000000000010,
		S_END4    = 13'b0000000000100,
		S_CLASS   = 13'b0000000001000,
		S_ENV_MUL = 13'b0000000010000,
		S_ENV_DIV = 13'b0000000100000,
		S_AMP_MUL = 13'b0000001000000,
		S_SIN_X2  = 13'b0000010000000,
		S_SIN_T   = 13'b0000100000000,
		S_SIN_T2  = 13'b0001000000000,
		S_SIN_S   = 13'b0010000000000,
		S_OUT_MUL = 13'b0100000000000,
		S_EMIT    = 13'b1000000000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [PHASE_W-1:0]    phase_step_q;
	logic [Q15_W-1:0]      amplitude_q;
	logic [LEN_W-1:0]      attack_len_q;
	logic [LEN_W-1:0]      decay_len_q;
	logic [Q15_W-1:0]      sustain_level_q;
	logic [LEN_W-1:0]      hold_len_q;
	logic [LEN_W-1:0]      release_len_q;
	logic [WAVE_SEL_W-1:0] wave_select_q;

	// Voice state.
	logic [PHASE_W-1:0]    phase_acc_q;
	logic [ELAPSED_W-1:0]  elapsed_q;
	logic                  playing_q;

	// Per-sample working registers.
	logic [ELAPSED_W-1:0]  t_q;
	logic [Q15_W-1:0]      wave_ph_q;
	logic [LEN_W:0]        e2_q;
	logic [LEN_W+1:0]      e3_q;
	logic [LEN_W+1:0]      e4_q;
	logic [STAGE_W-1:0]    stage_q;
	logic [Q15_W-1:0]      gain_q;
	logic [Q15_W-1:0]      scaled_q;
	logic [DIV_DEN_W-1:0]  den_q;
	logic [SIN_X_W-1:0]    sin_x_q;
	logic [SIN_X_W-1:0]    sin_x2_q;
	logic                  wave_neg_q;

	// Serial unit controls.
	logic [MUL_A_W-1:0]    mul_a_q;
	logic [MUL_B_W-1:0]    mul_b_q;
	logic                  mul_go_q;
	logic                  div_go_q;
	logic                  mul_done;
	logic [MUL_P_W-1:0]    mul_p;
	logic                  div_done;
	logic [DIV_Q_W-1:0]    div_quot;

	// Output register.
	logic                  out_valid_q;
	logic [Q15_W-1:0]      sample_out_q;
	logic [Q15_W-1:0]      gain_level_q;
	logic [STAGE_W-1:0]    env_stage_q;

	logic in_take;
	logic out_take;
	logic cfg_take;
	logic out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	assign cfg_take  = cfg_valid && cfg_ready;
	assign out_free  = !out_valid_q || !out_stall;

	// Amplitude and sustain above unity are treated as unity.
	logic [Q15_W-1:0] amp_clip;
	logic [Q15_W-1:0] sus_clip;

	assign amp_clip = (amplitude_q > Q15_ONE) ? Q15_ONE : amplitude_q;
	assign sus_clip = (sustain_level_q > Q15_ONE) ? Q15_ONE : sustain_level_q;

	// Timer for this sample: note_on restarts it at zero.
	logic [ELAPSED_W-1:0] t_new;

	assign t_new = note_on ? '0 : elapsed_q;

	// Envelope classification against the segment end points. A zero-length
	// segment never matches, so it is skipped without a divide by zero.
	logic                 lt_a, lt_e2, lt_e3, lt_e4;
	logic [STAGE_W-1:0]   cls_stage;
	logic [Q15_W-1:0]     cls_gain;
	logic                 cls_ramp;
	logic [MUL_A_W-1:0]   cls_a;
	logic [MUL_B_W-1:0]   cls_b;
	logic [DIV_DEN_W-1:0] cls_den;

	assign lt_a  = (t_q < ELAPSED_W'(attack_len_q));
	assign lt_e2 = (t_q < ELAPSED_W'(e2_q));
	assign lt_e3 = (t_q < ELAPSED_W'(e3_q));
	assign lt_e4 = (t_q < ELAPSED_W'(e4_q));

	always_comb begin
		cls_stage = STAGE_SILENT;
		cls_gain  = '0;
		cls_ramp  = 1'b0;
		cls_a     = '0;
		cls_b     = '0;
		cls_den   = attack_len_q;
		if (!playing_q) begin
			cls_stage = STAGE_SILENT;
		end else if (lt_a) begin
			// Rising ramp: t * 1.0 / attack_len.
			cls_stage = STAGE_ATTACK;
			cls_ramp  = 1'b1;
			cls_a     = MUL_A_W'(t_q[LEN_W-1:0]);
			cls_b     = MUL_B_W'(Q15_ONE);
			cls_den   = attack_len_q;
		end else if (lt_e2) begin
			// Falling from unity toward sustain; the drop is subtracted later.
			cls_stage = STAGE_DECAY;
			cls_ramp  = 1'b1;
			cls_a     = MUL_A_W'(t_q - ELAPSED_W'(attack_len_q));
			cls_b     = MUL_B_W'(Q15_ONE - sus_clip);
			cls_den   = decay_len_q;
		end else if (lt_e3) begin
			cls_stage = STAGE_HOLD;
			cls_gain  = sus_clip;
		end else if (lt_e4) begin
			// Samples left in the release, release_len - (t - e3), equal e4 - t.
			cls_stage = STAGE_RELEASE;
			cls_ramp  = 1'b1;
			cls_a     = MUL_A_W'(ELAPSED_W'(e4_q) - t_q);
			cls_b     = MUL_B_W'(sus_clip);
			cls_den   = release_len_q;
		end else begin
			cls_stage = STAGE_SILENT;
		end
	end

	// Gain at the end of a ramp divide. Decay counts down from unity.
	logic [Q15_W-1:0] ramp_gain;

	assign ramp_gain = (stage_q == STAGE_DECAY) ? (Q15_ONE - div_quot) : div_quot;

	// Square, triangle and sawtooth straight from the top phase bits, as a
	// sign and a magnitude for the unsigned multiplier.
	logic signed [17:0] saw_v;
	logic signed [17:0] tri_d;
	logic signed [17:0] lin_v;
	logic               lin_neg;
	logic [Q15_W-1:0]   lin_mag;

	always_comb begin
		saw_v = $signed({2'b00, wave_ph_q}) - 18'sd32768;
		tri_d = saw_v[17] ? -saw_v : saw_v;
		case (wave_select_q)
			WAVE_SQUARE: begin
				lin_v = wave_ph_q[Q15_W-1] ? -18'sd32768 : 18'sd32768;
			end
			WAVE_TRIANGLE: begin
				lin_v = (tri_d <<< 1) - 18'sd32768;
			end
			default: begin
				lin_v = saw_v;
			end
		endcase
		lin_neg = lin_v[17];
		lin_mag = lin_neg ? Q15_W'(-lin_v) : Q15_W'(lin_v);
	end

	// Sine: the top two phase bits pick the quadrant, the next bits index the
	// quarter wave, mirrored in odd quadrants and negated in the lower half.
	logic [1:0]                 sin_quad;
	logic [SINE_TABLE_BITS-1:0] sin_idx;
	logic [SINE_TABLE_BITS:0]   sin_k;
	logic [SIN_X_W-1:0]         sin_x;
	logic [SIN_X_W-1:0]         sin_t;
	logic [SIN_X_W-1:0]         sin_t2;
	logic [18:0]                sin_s;
	logic [19:0]                sin_r;
	logic [Q15_W-1:0]           sin_mag;

	assign sin_quad = wave_ph_q[Q15_W-1 -: 2];
	assign sin_idx  = wave_ph_q[Q15_W-3 -: SINE_TABLE_BITS];
	assign sin_k    = sin_quad[0] ? (SIN_Q - {1'b0, sin_idx}) : {1'b0, sin_idx};
	assign sin_x    = SIN_X_W'(sin_k) << (16 - SINE_TABLE_BITS);

	// Polynomial terms from the product just finished, each truncated by 16.
	assign sin_t  = SIN_C3 - mul_p[32:16];
	assign sin_t2 = SIN_C1 - mul_p[32:16];
	assign sin_s  = mul_p[34:16];
	assign sin_r  = (20'(sin_s) + 20'd1) >> 1;
	assign sin_mag = (sin_r > 20'(Q15_MAX_POS)) ? Q15_MAX_POS : Q15_W'(sin_r);

	// Final scaling: floor for positive products, rounding away from zero
	// for negative ones; only positive values saturate, at just below unity.
	logic [30:0]      out_mag;
	logic [Q15_W-1:0] pos_v;
	logic [Q15_W:0]   neg_c;
	logic [Q15_W-1:0] emit_sample;

	assign out_mag = mul_p[30:0];
	assign pos_v   = (out_mag[30:15] > Q15_MAX_POS) ? Q15_MAX_POS : out_mag[30:15];
	assign neg_c   = (Q15_W+1)'(out_mag[30:15]) + (Q15_W+1)'(|out_mag[14:0]);
	assign emit_sample = wave_neg_q ? Q15_W'(17'd0 - neg_c) : pos_v;

	sva_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.p      (mul_p)
	);

	sva_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go_q),
		.num    (mul_p[DIV_NUM_W-1:0]),
		.den    (den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			phase_step_q    <= RST_PHASE_STEP;
			amplitude_q     <= RST_AMPLITUDE;
			attack_len_q    <= RST_ATTACK_LEN;
			decay_len_q     <= RST_DECAY_LEN;
			sustain_level_q <= RST_SUSTAIN_LEVEL;
			hold_len_q      <= RST_HOLD_LEN;
			release_len_q   <= RST_RELEASE_LEN;
			wave_select_q   <= WAVE_SINE;
			phase_acc_q     <= '0;
			elapsed_q       <= '0;
			playing_q       <= 1'b0;
			t_q             <= '0;
			wave_ph_q       <= '0;
			e2_q            <= '0;
			e3_q            <= '0;
			e4_q            <= '0;
			stage_q         <= STAGE_SILENT;
			gain_q          <= '0;
			scaled_q        <= '0;
			den_q           <= '0;
			sin_x_q         <= '0;
			sin_x2_q        <= '0;
			wave_neg_q      <= 1'b0;
			mul_a_q         <= '0;
			mul_b_q         <= '0;
			mul_go_q        <= 1'b0;
			div_go_q        <= 1'b0;
			out_valid_q     <= 1'b0;
			sample_out_q    <= '0;
			gain_level_q    <= '0;
			env_stage_q     <= STAGE_SILENT;
		end else begin
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			if (out_take) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_take) begin
				unique case (cfg_index)
					REG_PHASE_STEP:    phase_step_q    <= cfg_data;
					REG_AMPLITUDE:     amplitude_q     <= cfg_data[Q15_W-1:0];
					REG_ATTACK_LEN:    attack_len_q    <= cfg_data[LEN_W-1:0];
					REG_DECAY_LEN:     decay_len_q     <= cfg_data[LEN_W-1:0];
					REG_SUSTAIN_LEVEL: sustain_level_q <= cfg_data[Q15_W-1:0];
					REG_HOLD_LEN:      hold_len_q      <= cfg_data[LEN_W-1:0];
					REG_RELEASE_LEN:   release_len_q   <= cfg_data[LEN_W-1:0];
					REG_WAVE_SELECT:   wave_select_q   <= cfg_data[WAVE_SEL_W-1:0];
					default: begin
					end
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						// The wave is sampled at the current phase, then the
						// phase and the timer advance; the timer saturates.
						t_q         <= t_new;
						wave_ph_q   <= phase_acc_q[PHASE_W-1 -: Q15_W];
						phase_acc_q <= phase_acc_q + phase_step_q;
						elapsed_q   <= (t_new == ELAPSED_MAX) ? t_new
							: t_new + ELAPSED_W'(1);
						playing_q   <= playing_q | note_on;
						e2_q        <= (LEN_W+1)'(attack_len_q) + (LEN_W+1)'(decay_len_q);
						state_q     <= S_END3;
					end
				end
				S_END3: begin
					e3_q    <= (LEN_W+2)'(e2_q) + (LEN_W+2)'(hold_len_q);
					state_q <= S_END4;
				end
				S_END4: begin
					e4_q    <= e3_q + (LEN_W+2)'(release_len_q);
					state_q <= S_CLASS;
				end
				S_CLASS: begin
					stage_q  <= cls_stage;
					gain_q   <= cls_gain;
					den_q    <= cls_den;
					mul_a_q  <= cls_ramp ? cls_a : MUL_A_W'(amp_clip);
					mul_b_q  <= cls_ramp ? cls_b : MUL_B_W'(cls_gain);
					mul_go_q <= 1'b1;
					state_q  <= cls_ramp ? S_ENV_MUL : S_AMP_MUL;
				end
				S_ENV_MUL: begin
					if (mul_done) begin
						div_go_q <= 1'b1;
						state_q  <= S_ENV_DIV;
					end
				end
				S_ENV_DIV: begin
					if (div_done) begin
						gain_q   <= ramp_gain;
						mul_a_q  <= MUL_A_W'(amp_clip);
						mul_b_q  <= MUL_B_W'(ramp_gain);
						mul_go_q <= 1'b1;
						state_q  <= S_AMP_MUL;
					end
				end
				S_AMP_MUL: begin
					if (mul_done) begin
						scaled_q <= mul_p[30:15];
						mul_go_q <= 1'b1;
						if (wave_select_q == WAVE_SINE) begin
							sin_x_q    <= sin_x;
							wave_neg_q <= sin_quad[1];
							mul_a_q    <= MUL_A_W'(sin_x);
							mul_b_q    <= MUL_B_W'(sin_x);
							state_q    <= S_SIN_X2;
						end else begin
							wave_neg_q <= lin_neg;
							mul_a_q    <= MUL_A_W'(mul_p[30:15]);
							mul_b_q    <= MUL_B_W'(lin_mag);
							state_q    <= S_OUT_MUL;
						end
					end
				end
				S_SIN_X2: begin
					if (mul_done) begin
						sin_x2_q <= mul_p[32:16];
						mul_a_q  <= MUL_A_W'(mul_p[32:16]);
						mul_b_q  <= MUL_B_W'(SIN_C5);
						mul_go_q <= 1'b1;
						state_q  <= S_SIN_T;
					end
				end
				S_SIN_T: begin
					if (mul_done) begin
						mul_a_q  <= MUL_A_W'(sin_x2_q);
						mul_b_q  <= MUL_B_W'(sin_t);
						mul_go_q <= 1'b1;
						state_q  <= S_SIN_T2;
					end
				end
				S_SIN_T2: begin
					if (mul_done) begin
						mul_a_q  <= MUL_A_W'(sin_x_q);
						mul_b_q  <= MUL_B_W'(sin_t2);
						mul_go_q <= 1'b1;
						state_q  <= S_SIN_S;
					end
				end
				S_SIN_S: begin
					if (mul_done) begin
						mul_a_q  <= MUL_A_W'(scaled_q);
						mul_b_q  <= MUL_B_W'(sin_mag);
						mul_go_q <= 1'b1;
						state_q  <= S_OUT_MUL;
					end
				end
				S_OUT_MUL: begin
					if (mul_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					// The product stays on the multiplier output until the
					// output register can take this beat.
					if (out_free) begin
						sample_out_q <= emit_sample;
						gain_level_q <= gain_q;
						env_stage_q  <= stage_q;
						out_valid_q  <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = $signed(sample_out_q);
	assign gain_level = gain_level_q;
	assign env_stage  = env_stage_q;

endmodule
